// ===== rtl/arp_cache_and_responder_top_defines.svh =====
// Assertion macros for the ARP cache and responder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/arpc_pkg.sv =====
// Shared types and constants for the ARP cache and responder.
// No dependencies.
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd42;

  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Configuration space: 64-bit registers at 8-byte spacing, selected by paddr[3]
  localparam int   CFG_ADDR_W  = 4;
  localparam int   CFG_DATA_W  = 64;
  localparam int   CFG_SEL_BIT = 3;
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] frame_len;
    logic [15:0] arp_opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] tgt_ip;
  } arp_in_t;

  typedef struct packed {
    logic        lookup_hit;
    logic [47:0] found_mac;
    logic        reply_valid;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_tgt_ip;
  } arp_out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } cache_ent_t;

endpackage

// ===== rtl/arpc_mem.sv =====
// Cache storage: IP and MAC memories with one registered read port,
// one write port, and per-entry valid flops. Depends on arpc_pkg.
module arpc_mem import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int AW = $clog2(CACHE_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_vld,
  output cache_ent_t    rd_ent,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cache_ent_t    wr_ent
);

  logic [31:0] ip_mem  [CACHE_ENTRIES];
  logic [47:0] mac_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vld_r;
  logic       rd_vld_r;
  cache_ent_t rd_ent_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_addr]  <= wr_ent.ip;
      mac_mem[wr_addr] <= wr_ent.mac;
    end
    rd_ent_r.ip  <= ip_mem[rd_addr];
    rd_ent_r.mac <= mac_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_vld = rd_vld_r;
  assign rd_ent = rd_ent_r;

endmodule

// ===== rtl/arpc_ctrl.sv =====
// Sequencer: scans the cache one entry per cycle, resolves the slot,
// writes back and builds the result. Depends on arpc_pkg.
module arpc_ctrl import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int AW = $clog2(CACHE_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  arp_in_t       in_data,
  input  logic [31:0]   own_ip,
  output logic          res_vld,
  input  logic          res_take,
  output arp_out_t      res_data,
  output logic [AW-1:0] rd_addr,
  input  logic          rd_vld,
  input  cache_ent_t    rd_ent,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output cache_ent_t    wr_ent
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_LAST    = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]    state_r, state_nxt;
  arp_in_t       item_r;
  arp_out_t      res_r;
  arp_out_t      res_nxt;
  logic [AW-1:0] cnt_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [47:0]   hit_mac_r;
  logic          free_r;
  logic [AW-1:0] free_idx_r;
  logic [31:0]   key;
  logic          in_xfer;
  logic          short_frame;
  logic          reply;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign short_frame = (in_data.mode == MODE_FRAME) && (in_data.frame_len < MIN_FRAME_LEN);
  assign key         = (item_r.mode == MODE_LOOKUP) ? item_r.tgt_ip : item_r.src_ip;
  assign reply       = (item_r.arp_opcode == ARP_OP_REQUEST) && (item_r.tgt_ip == own_ip);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = short_frame ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == AW'(CACHE_ENTRIES - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:    state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (item_r.mode == MODE_LOOKUP) begin
      res_nxt.lookup_hit = hit_r;
      res_nxt.found_mac  = hit_r ? hit_mac_r : 48'd0;
    end else if (reply) begin
      res_nxt.reply_valid   = 1'b1;
      res_nxt.reply_dst_mac = item_r.src_mac;
      res_nxt.reply_tgt_ip  = item_r.src_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (in_xfer) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end
      // Compare the entry read last cycle; keep the first match and first free slot
      if (cmp_vld_r) begin
        if (rd_vld && (rd_ent.ip == key) && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!rd_vld && !free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
    if (in_xfer) begin
      item_r <= in_data;
      res_r  <= '0;
    end
    if (cmp_vld_r) begin
      if (rd_vld && (rd_ent.ip == key) && !hit_r) begin
        hit_idx_r <= cmp_idx_r;
        hit_mac_r <= rd_ent.mac;
      end
      if (!rd_vld && !free_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (state_r == ST_RESOLVE) begin
      res_r <= res_nxt;
    end
  end

  // Scan reads walk the table; writeback lands before the next item's scan starts
  assign rd_addr    = cnt_r;
  assign wr_en      = (state_r == ST_RESOLVE) && (item_r.mode == MODE_FRAME);
  assign wr_addr    = hit_r ? hit_idx_r : (free_r ? free_idx_r : '0);
  assign wr_ent.ip  = item_r.src_ip;
  assign wr_ent.mac = item_r.src_mac;

  assign res_vld  = (state_r == ST_DONE);
  assign res_data = res_r;

endmodule

// ===== rtl/arp_cache_and_responder_top.sv =====
// ARP cache and responder: top level with config registers and output register.
// Depends on arpc_pkg, arpc_mem, arpc_ctrl and the assertion macro header.
//
// Usage:
//   in_valid/in_ready/in_data take one item: a received ARP frame (mode 0)
//   or a cache lookup of tgt_ip (mode 1). Every item yields exactly one
//   transfer on out_valid/out_ready/out_data.
//   own_ip (paddr 0x0) and own_mac (paddr 0x8) are written over the APB port;
//   the user must write them only while the block is idle, as the block itself
//   does not enforce it. pready is always high.
//   A short frame goes straight to its result; any other item waits on the scan
//   that reads one cache entry per cycle through the single memory read port.
//   One item is in work at a time: a new item is taken only once the
//   result of the last has gone to the output register.
//   Reset clears the valid flags of all entries, the config registers and
//   the output valid flag; no clearing pass is needed.
//   A result waiting in the output register does not block the next item;
//   the sequencer holds its finished result only until the register frees.
`include "arp_cache_and_responder_top_defines.svh"

module arp_cache_and_responder_top import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int AW = $clog2(CACHE_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arp_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output arp_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [31:0]   own_ip_r;
  logic [47:0]   own_mac_r;
  logic          cfg_wr;
  logic          out_valid_r;
  arp_out_t      out_data_r;
  logic          res_vld;
  logic          res_take;
  arp_out_t      res_data;
  logic [AW-1:0] rd_addr;
  logic          rd_vld;
  cache_ent_t    rd_ent;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  cache_ent_t    wr_ent;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[CFG_SEL_BIT] == REG_OWN_MAC) begin
        own_mac_r <= pwdata[47:0];
      end else begin
        own_ip_r <= pwdata[31:0];
      end
    end
  end

  assign prdata = (paddr[CFG_SEL_BIT] == REG_OWN_IP) ? {32'd0, own_ip_r} : {16'd0, own_mac_r};

  arpc_ctrl #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .own_ip   (own_ip_r),
    .res_vld  (res_vld),
    .res_take (res_take),
    .res_data (res_data),
    .rd_addr  (rd_addr),
    .rd_vld   (rd_vld),
    .rd_ent   (rd_ent),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_ent   (wr_ent)
  );

  arpc_mem #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_vld  (rd_vld),
    .rd_ent  (rd_ent),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_ent  (wr_ent)
  );

  // Load the output register when it is empty or being drained this cycle
  assign res_take = res_vld && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ARPC_ASSERT_NOW(a_idle_no_result, in_ready, !res_vld, "sequencer idle with a pending result")
  `ARPC_ASSERT_NOW(a_hit_or_reply, out_valid_r && out_data_r.lookup_hit,
                   !out_data_r.reply_valid, "lookup hit and reply in one result")
  `ARPC_ASSERT_NOW(a_miss_zero_mac, out_valid_r && !out_data_r.lookup_hit,
                   out_data_r.found_mac == 48'd0, "found_mac nonzero on a miss")
  `ARPC_ASSERT_NEXT(a_take_loads, res_take, out_valid_r, "result taken but output empty")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for arp_cache_and_responder_top: drives frames and lookups,
// predicts cache contents and reply indications, checks every result transfer.
// Depends on arpc_pkg and the RTL top level.
module testbench import arpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = CACHE_ENTRIES_DEF;
  localparam int ITEMS_PER_SET = 375;
  localparam int NUM_SETTINGS  = 4;
  localparam int POOL_SIZE     = 24;
  localparam int HOLD_AT       = 1500;
  localparam int HOLD_LEN      = 600;
  localparam int IDLE_LIMIT    = 4000;

  // Predicts the cache and the responder, and holds the results still to come.
  class arp_scoreboard;
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    bit          slot_valid[ENTRIES];
    logic [31:0] slot_ip[ENTRIES];
    logic [47:0] slot_mac[ENTRIES];
    arp_out_t    pending_results[$];
    int          mismatches;
    int          items_seen;
    int          hits_seen;
    int          replies_seen;

    function new();
      own_ip       = '0;
      own_mac      = '0;
      mismatches   = 0;
      items_seen   = 0;
      hits_seen    = 0;
      replies_seen = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_ip[i]    = '0;
        slot_mac[i]   = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [63:0] value);
      if (idx == REG_OWN_IP) own_ip = value[31:0];
      else own_mac = value[47:0];
    endfunction

    function int match_slot(logic [31:0] ip);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && slot_ip[i] == ip) return i;
      return -1;
    endfunction

    function void store_pair(logic [31:0] ip, logic [47:0] mac);
      int slot;
      slot = match_slot(ip);
      if (slot < 0) begin
        // lowest free slot, or slot 0 once the table is full
        slot = 0;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!slot_valid[i]) slot = i;
        slot_ip[slot]    = ip;
        slot_valid[slot] = 1'b1;
      end
      slot_mac[slot] = mac;
    endfunction

    function void note_item(arp_in_t item);
      arp_out_t res;
      int       slot;
      res = '0;
      items_seen++;
      if (item.mode == MODE_LOOKUP) begin
        slot = match_slot(item.tgt_ip);
        if (slot >= 0) begin
          res.lookup_hit = 1'b1;
          res.found_mac  = slot_mac[slot];
        end
      end else if (item.frame_len >= MIN_FRAME_LEN) begin
        store_pair(item.src_ip, item.src_mac);
        if (item.arp_opcode == ARP_OP_REQUEST && item.tgt_ip == own_ip) begin
          res.reply_valid   = 1'b1;
          res.reply_dst_mac = item.src_mac;
          res.reply_tgt_ip  = item.src_ip;
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(arp_out_t got);
      arp_out_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: %h", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (want.lookup_hit) hits_seen++;
      if (want.reply_valid) replies_seen++;
      if (got.lookup_hit !== want.lookup_hit) begin
        $error("lookup_hit: expected %h, got %h", want.lookup_hit, got.lookup_hit);
        mismatches++;
      end
      if (got.found_mac !== want.found_mac) begin
        $error("found_mac: expected %h, got %h", want.found_mac, got.found_mac);
        mismatches++;
      end
      if (got.reply_valid !== want.reply_valid) begin
        $error("reply_valid: expected %h, got %h", want.reply_valid, got.reply_valid);
        mismatches++;
      end
      if (got.reply_dst_mac !== want.reply_dst_mac) begin
        $error("reply_dst_mac: expected %h, got %h", want.reply_dst_mac, got.reply_dst_mac);
        mismatches++;
      end
      if (got.reply_tgt_ip !== want.reply_tgt_ip) begin
        $error("reply_tgt_ip: expected %h, got %h",
               want.reply_tgt_ip, got.reply_tgt_ip);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  arp_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  arp_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  arp_scoreboard sb;
  logic [31:0]   ip_pool[POOL_SIZE];
  int            burst_left;
  int            idle_cycles;
  int            rx_cycle;
  int            hold_left;
  int            stall_style;
  int            style_left;

  arp_cache_and_responder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic arp_in_t frame_item(logic [15:0] len, logic [15:0] op,
                                         logic [31:0] sip, logic [47:0] smac,
                                         logic [31:0] tip);
    arp_in_t it;
    it.mode       = MODE_FRAME;
    it.frame_len  = len;
    it.arp_opcode = op;
    it.src_ip     = sip;
    it.src_mac    = smac;
    it.tgt_ip     = tip;
    return it;
  endfunction

  function automatic arp_in_t lookup_item(logic [31:0] tip);
    arp_in_t it;
    // fields other than tgt_ip are don't-care for a lookup
    it = frame_item(16'($urandom), 16'($urandom), $urandom, rand_mac(), tip);
    it.mode = MODE_LOOKUP;
    return it;
  endfunction

  function automatic arp_in_t make_item();
    arp_in_t it;
    int      kind;
    int      pick;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    it = frame_item(16'($urandom), 16'($urandom), $urandom, rand_mac(), $urandom);
    it.mode = 1'($urandom_range(0, 1));
    if (kind < 75) begin
      // well-formed frames and lookups over a small address pool
      if (kind < 40) begin
        it.mode = MODE_FRAME;
        it.frame_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(MIN_FRAME_LEN, 64))
                                                   : 16'($urandom_range(MIN_FRAME_LEN, 65535));
        if (pick < 60) it.arp_opcode = ARP_OP_REQUEST;
        else if (pick < 85) it.arp_opcode = 16'd2;
        if ($urandom_range(0, 99) < 85) it.src_ip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
        pick = $urandom_range(0, 99);
        if (pick < 60) it.tgt_ip = sb.own_ip;
        else if (pick < 80) it.tgt_ip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
      end else begin
        it.mode = MODE_LOOKUP;
        if (pick < 80) it.tgt_ip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
        else if (pick < 90) it.tgt_ip = sb.own_ip;
      end
    end else if (kind < 85) begin
      // runt frame aimed at this host
      it.mode      = MODE_FRAME;
      it.frame_len = 16'($urandom_range(0, MIN_FRAME_LEN - 1));
      if (pick < 50) it.arp_opcode = ARP_OP_REQUEST;
      it.src_ip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
      it.tgt_ip = sb.own_ip;
    end
    return it;
  endfunction

  task automatic drive_item(arp_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offer items in bursts of random length, with random gaps between bursts.
  task automatic offer_item(arp_in_t item);
    if (burst_left == 0) begin
      idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 20);
    end
    drive_item(item);
    burst_left--;
  endtask

  task automatic write_reg(logic idx, logic [63:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    addr = '0;
    addr[CFG_SEL_BIT] = idx;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic directed_items();
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    ip_a = ip_pool[0];
    ip_b = ip_pool[1];
    offer_item(lookup_item(ip_a));
    offer_item(frame_item(MIN_FRAME_LEN - 16'd1, ARP_OP_REQUEST, ip_a, rand_mac(), sb.own_ip));
    offer_item(lookup_item(ip_a));
    offer_item(frame_item(MIN_FRAME_LEN, ARP_OP_REQUEST, ip_a, rand_mac(), sb.own_ip));
    offer_item(lookup_item(ip_a));
    offer_item(frame_item(16'hFFFF, 16'd2, ip_a, rand_mac(), sb.own_ip));
    offer_item(lookup_item(ip_a));
    offer_item(frame_item(16'd0, ARP_OP_REQUEST, ip_b, rand_mac(), sb.own_ip));
    offer_item(frame_item(MIN_FRAME_LEN, ARP_OP_REQUEST, ip_b, rand_mac(), ~sb.own_ip));
    offer_item(frame_item(MIN_FRAME_LEN, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                          32'hFFFF_FFFF));
    offer_item(frame_item(16'd64, ARP_OP_REQUEST, 32'h0, 48'h0, sb.own_ip));
    offer_item(lookup_item(32'hFFFF_FFFF));
    offer_item(lookup_item(32'h0));
    // fill the remaining slots, then one more to overwrite slot 0
    for (int i = 2; i <= 14; i++)
      offer_item(frame_item(16'(MIN_FRAME_LEN + i), 16'(i - 2), ip_pool[i], rand_mac(),
                            sb.own_ip));
    offer_item(lookup_item(ip_a));
    offer_item(lookup_item(ip_pool[14]));
  endtask

  // Result side: changing stall styles, plus one long hold-off to back up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      rx_cycle    = 0;
      hold_left   = 0;
      stall_style = 0;
      style_left  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 3);
          style_left  = $urandom_range(32, 256);
        end
        style_left--;
        case (stall_style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // Observe both channels at the rising edge; also the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_item(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    logic [31:0] set_ip[NUM_SETTINGS];
    logic [47:0] set_mac[NUM_SETTINGS];
    int          leftover;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = ($urandom & 32'hFFFF_FF00) | i;

    set_ip[0]  = $urandom;
    set_mac[0] = rand_mac();
    set_ip[1]  = 32'hFFFF_FFFF;
    set_mac[1] = 48'hFFFF_FFFF_FFFF;
    set_ip[2]  = 32'h0;
    set_mac[2] = 48'h0;
    set_ip[3]  = ip_pool[$urandom_range(0, POOL_SIZE-1)];
    set_mac[3] = rand_mac();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(REG_OWN_IP, {32'h0, set_ip[s]});
      write_reg(REG_OWN_MAC, {16'h0, set_mac[s]});
      if (s == 0) directed_items();
      for (int n = 0; n < ITEMS_PER_SET; n++) offer_item(make_item());
      wait_drained();
    end

    leftover = sb.pending_results.size();
    if (leftover != 0) $error("%0d expected results never arrived", leftover);
    $display("Ran %0d frames and lookups over %0d register settings:", sb.items_seen,
             NUM_SETTINGS);
    $display("  %0d lookup hits, %0d reply indications, %0d mismatches", sb.hits_seen,
             sb.replies_seen, sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_mem.sv
rtl/arpc_ctrl.sv
rtl/arp_cache_and_responder_top.sv
bench/testbench.sv
